### rtl/bblur_pkg.sv
// Shared constants, types and helpers of the 3x3 border-normalized box blur.
// No dependencies; every other file of the block but bblur_ram imports this package.
`default_nettype none

package bblur_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int FRAC_BITS  = 15;

	localparam int SAMPLE_W  = FRAC_BITS + 1;        // Q1.FRAC_BITS, 1.0 included
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = $clog2(MAX_HEIGHT);
	localparam int CFG_W     = 11;                    // frame size registers
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [CFG_W-1:0] SIZE_MIN        = CFG_W'(2);
	localparam logic [CFG_W-1:0] WIDTH_MAX       = CFG_W'(MAX_WIDTH);
	localparam logic [CFG_W-1:0] HEIGHT_MAX      = CFG_W'(MAX_HEIGHT);
	localparam logic [CFG_W-1:0] SIZE_RESET      = CFG_W'(1024);

	// Line store entry packs the older row above the newer row
	localparam int RAM_W = 2 * SAMPLE_W;

	// Window sum plus rounding offset; nine full-scale samples fit
	localparam int SUM_W       = SAMPLE_W + 5;
	localparam int RECIP_SHIFT = SUM_W + 4;
	localparam int RECIP_W     = RECIP_SHIFT - 2;
	localparam int PROD_W      = SUM_W + RECIP_W;

	localparam longint RECIP_BASE = longint'(1) << RECIP_SHIFT;
	// Rounded-up reciprocals; exact floor for every sum below 2^SUM_W
	localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'((RECIP_BASE + 8) / 9);
	localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'((RECIP_BASE + 5) / 6);

	localparam logic [SUM_W-1:0] HALF_9 = SUM_W'(9 / 2);
	localparam logic [SUM_W-1:0] HALF_6 = SUM_W'(6 / 2);
	localparam logic [SUM_W-1:0] HALF_4 = SUM_W'(4 / 2);

	// Result queue
	localparam int QDEPTH    = 8;
	localparam int Q_AW      = $clog2(QDEPTH);
	localparam int RES_MAX   = 4;
	localparam int RES_CNT_W = $clog2(RES_MAX + 1);

	typedef enum logic [1:0] {
		DIV_9,
		DIV_6,
		DIV_4
	} div_sel_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		div_sel_t         div;
		logic [COL_W-1:0] x;
		logic [ROW_W-1:0] y;
		logic             run_last;
		logic             frame_last;
	} res_t;

	function automatic logic [SUM_W-1:0] half_of(input div_sel_t d);
		logic [SUM_W-1:0] h;
		case (d)
			DIV_9:   h = HALF_9;
			DIV_6:   h = HALF_6;
			DIV_4:   h = HALF_4;
			default: h = '0;
		endcase
		return h;
	endfunction

	function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
		input logic [CFG_W-1:0] maxv);
		logic [CFG_W-1:0] r;
		if (v < SIZE_MIN) begin
			r = SIZE_MIN;
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/bblur_in_if.sv
// Sample input channel of the box blur: valid, ready and one height sample.
// Depends on bblur_pkg for the sample width.
`default_nettype none

interface bblur_in_if;
	import bblur_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

### rtl/bblur_out_if.sv
// Result channel of the box blur: valid, ready, mean, coordinates and marks.
// Depends on bblur_pkg for field widths.
`default_nettype none

interface bblur_out_if;
	import bblur_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] blurred_sample;
	logic [COL_W-1:0]    out_column;
	logic [ROW_W-1:0]    out_row;
	logic                run_last;
	logic                frame_last;

	modport source (output valid, output blurred_sample, output out_column,
		output out_row, output run_last, output frame_last, input ready);
	modport sink   (input valid, input blurred_sample, input out_column,
		input out_row, input run_last, input frame_last, output ready);
endinterface

`default_nettype wire

### rtl/box_blur_3x3_edge_normalized_core.sv
// Top level of the 3x3 box blur with border-normalized mean over a raster frame.
// Depends on bblur_pkg, bblur_in_if, bblur_out_if and bblur_ram.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   sample_in
//   out_ch   out  valid/ready   blurred_sample, out_column, out_row, run_last, frame_last
//   cfg      in   cfg_we        cfg_index, cfg_data (frame_width, frame_height)
//
// One sample is accepted per cycle while the result queue has room for all of its
// results. The single output register drains one result per cycle while out_ch.ready
// is high; on the last row a sample yields up to four results, so input acceptance
// follows the output rate through an eight-entry result queue. The first result of a
// sample passes the stage-1 register, the queue and the output register to out_ch.
// Reset clears counters, window and queue and sets both sizes to 1024; the line
// store contents stay undefined until written. A stalled output fills the queue,
// then holds the stage-1 item and drops in_ch.ready.
`default_nettype none

module box_blur_3x3_edge_normalized_core (
	input  logic                           clk,
	input  logic                           arst_n,
	bblur_in_if.sink                       in_ch,
	bblur_out_if.source                    out_ch,
	input  logic                           cfg_we,
	input  logic [bblur_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bblur_pkg::CFG_W-1:0]     cfg_data
);
	import bblur_pkg::*;

	// ---------------- configuration ----------------
	logic [CFG_W-1:0] width_q, height_q;
	logic [CFG_W-1:0] w_eff, h_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_RESET;
			height_q <= SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w_eff = clamp_size(width_q, WIDTH_MAX);
	assign h_eff = clamp_size(height_q, HEIGHT_MAX);

	// ---------------- position counters ----------------
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             wrap_col;
	logic [COL_W-1:0] c_now;
	logic [CFG_W-1:0] r_pre;
	logic [ROW_W-1:0] r_now;
	logic             last_col_now, last_row_now;
	logic             in_go;

	// Row ends or frame restarts at once if the size shrank under the count
	always_comb begin
		wrap_col     = {1'b0, col_q} >= w_eff;
		c_now        = wrap_col ? '0 : col_q;
		r_pre        = wrap_col ? (CFG_W'(row_q) + CFG_W'(1)) : CFG_W'(row_q);
		r_now        = (r_pre >= h_eff) ? '0 : r_pre[ROW_W-1:0];
		last_col_now = {1'b0, c_now} == (w_eff - CFG_W'(1));
		last_row_now = CFG_W'(r_now) == (h_eff - CFG_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_go) begin
			if (last_col_now) begin
				col_q <= '0;
				row_q <= last_row_now ? '0 : (r_now + ROW_W'(1));
			end else begin
				col_q <= c_now + COL_W'(1);
				row_q <= r_now;
			end
		end
	end

	// ---------------- stage 1 and line stores ----------------
	logic                s1_v_q;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [COL_W-1:0]    c_s1;
	logic [ROW_W-1:0]    r_s1;
	logic                last_col_s1, last_row_s1;
	logic                s1_go;

	logic                ram_we, ram_re;
	logic [COL_W-1:0]    ram_waddr, ram_raddr;
	logic [RAM_W-1:0]    ram_wdata, ram_rdata;
	logic [SAMPLE_W-1:0] rd_older, rd_newer;

	assign in_ch.ready = !s1_v_q || s1_go;
	assign in_go       = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (in_ch.ready) begin
			s1_v_q <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_go) begin
			sample_s1   <= in_ch.sample_in;
			c_s1        <= c_now;
			r_s1        <= r_now;
			last_col_s1 <= last_col_now;
			last_row_s1 <= last_row_now;
		end
	end

	// Read on accept so the data holds while stage 1 stalls
	assign ram_re    = in_go;
	assign ram_raddr = c_now;
	assign rd_older  = ram_rdata[RAM_W-1:SAMPLE_W];
	assign rd_newer  = ram_rdata[SAMPLE_W-1:0];
	// Age the column: newer row moves to older, the new sample becomes newer
	assign ram_we    = s1_go;
	assign ram_waddr = c_s1;
	assign ram_wdata = {rd_newer, sample_s1};

	bblur_ram #(
		.WIDTH (RAM_W),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ---------------- window and result sums ----------------
	logic [SAMPLE_W-1:0] win_q [3][3];   // [column c-2..c][row r-2..r]
	logic [SAMPLE_W-1:0] nw [3][3];
	logic [SUM_W-1:0]    col_a [3];
	logic [SUM_W-1:0]    col_b [3];
	logic                c_ge1, c_ge2, r_ge1, r_ge2;
	div_sel_t            div0, div1, div2;
	res_t                res [RES_MAX];
	logic [RES_MAX-1:0]  res_v;
	logic [RES_CNT_W-1:0] res_cnt;
	logic [Q_AW-1:0]     res_off [RES_MAX];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			nw[0][j] = win_q[1][j];
			nw[1][j] = win_q[2][j];
		end
		nw[2][0] = rd_older;
		nw[2][1] = rd_newer;
		nw[2][2] = sample_s1;
	end

	assign c_ge1 = c_s1 != '0;
	assign c_ge2 = c_s1 >= COL_W'(2);
	assign r_ge1 = r_s1 != '0;
	assign r_ge2 = r_s1 >= ROW_W'(2);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			col_b[i] = SUM_W'(nw[i][1]) + SUM_W'(nw[i][2]);
			col_a[i] = col_b[i] + (r_ge2 ? SUM_W'(nw[i][0]) : '0);
		end
	end

	always_comb begin
		if (c_ge2 && r_ge2) begin
			div0 = DIV_9;
		end else if (c_ge2 || r_ge2) begin
			div0 = DIV_6;
		end else begin
			div0 = DIV_4;
		end
		div1 = r_ge2 ? DIV_6 : DIV_4;
		div2 = c_ge2 ? DIV_6 : DIV_4;

		res_v[0] = r_ge1 && c_ge1;
		res_v[1] = r_ge1 && last_col_s1;
		res_v[2] = last_row_s1 && c_ge1;
		res_v[3] = last_row_s1 && last_col_s1;

		// Upper row results: pixels (c-1, r-1) and (c, r-1)
		res[0].sum = (c_ge2 ? col_a[0] : '0) + col_a[1] + col_a[2] + half_of(div0);
		res[0].div = div0;
		res[0].x   = c_s1 - COL_W'(1);
		res[0].y   = r_s1 - ROW_W'(1);
		res[1].sum = col_a[1] + col_a[2] + half_of(div1);
		res[1].div = div1;
		res[1].x   = c_s1;
		res[1].y   = r_s1 - ROW_W'(1);
		// Bottom row results: pixels (c-1, r) and (c, r)
		res[2].sum = (c_ge2 ? col_b[0] : '0) + col_b[1] + col_b[2] + half_of(div2);
		res[2].div = div2;
		res[2].x   = c_s1 - COL_W'(1);
		res[2].y   = r_s1;
		res[3].sum = col_b[1] + col_b[2] + HALF_4;
		res[3].div = DIV_4;
		res[3].x   = c_s1;
		res[3].y   = r_s1;

		res[0].run_last = !(res_v[1] || res_v[2] || res_v[3]);
		res[1].run_last = !(res_v[2] || res_v[3]);
		res[2].run_last = !res_v[3];
		res[3].run_last = 1'b1;
		res[0].frame_last = 1'b0;
		res[1].frame_last = 1'b0;
		res[2].frame_last = 1'b0;
		res[3].frame_last = 1'b1;

		// Pack valid results at consecutive queue slots
		res_off[0] = '0;
		for (int k = 1; k < RES_MAX; k++) begin
			res_off[k] = res_off[k-1] + Q_AW'(res_v[k-1]);
		end
		res_cnt = RES_CNT_W'(res_off[RES_MAX-1]) + RES_CNT_W'(res_v[RES_MAX-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (s1_go) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= nw[i][j];
				end
			end
		end
	end

	// ---------------- result queue ----------------
	res_t            q_mem [QDEPTH];
	logic [Q_AW-1:0] q_wr_q, q_rd_q;
	logic [Q_AW:0]   q_count_q;
	logic [Q_AW:0]   q_free;
	logic            q_pop;
	res_t            q_head;

	assign q_free = (Q_AW+1)'(QDEPTH) - q_count_q;
	// Advance stage 1 only when all its results fit
	assign s1_go  = s1_v_q && ((Q_AW+1)'(res_cnt) <= q_free);
	assign q_head = q_mem[q_rd_q];

	always_ff @(posedge clk) begin
		if (s1_go) begin
			for (int k = 0; k < RES_MAX; k++) begin
				if (res_v[k]) begin
					q_mem[q_wr_q + res_off[k]] <= res[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_q    <= '0;
			q_rd_q    <= '0;
			q_count_q <= '0;
		end else begin
			if (s1_go) begin
				q_wr_q <= q_wr_q + Q_AW'(res_cnt);
			end
			if (q_pop) begin
				q_rd_q <= q_rd_q + Q_AW'(1);
			end
			q_count_q <= q_count_q + (s1_go ? (Q_AW+1)'(res_cnt) : '0)
				- (Q_AW+1)'(q_pop);
		end
	end

	// ---------------- normalize and output register ----------------
	logic                out_v_q;
	logic [SAMPLE_W-1:0] mean_q;
	logic [COL_W-1:0]    x_q;
	logic [ROW_W-1:0]    y_q;
	logic                run_last_q, frame_last_q;
	logic [RECIP_W-1:0]  recip;
	logic [PROD_W-1:0]   prod;
	logic [SAMPLE_W-1:0] mean;

	assign q_pop = (q_count_q != '0) && (!out_v_q || out_ch.ready);

	always_comb begin
		recip = (q_head.div == DIV_9) ? RECIP_9 : RECIP_6;
		prod  = PROD_W'(q_head.sum) * PROD_W'(recip);
		case (q_head.div)
			DIV_9, DIV_6: mean = prod[RECIP_SHIFT +: SAMPLE_W];
			DIV_4:        mean = q_head.sum[SAMPLE_W+1:2];
			default:      mean = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (!out_v_q || out_ch.ready) begin
			out_v_q <= q_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			mean_q       <= mean;
			x_q          <= q_head.x;
			y_q          <= q_head.y;
			run_last_q   <= q_head.run_last;
			frame_last_q <= q_head.frame_last;
		end
	end

	assign out_ch.valid          = out_v_q;
	assign out_ch.blurred_sample = mean_q;
	assign out_ch.out_column     = x_q;
	assign out_ch.out_row        = y_q;
	assign out_ch.run_last       = run_last_q;
	assign out_ch.frame_last     = frame_last_q;

	// ---------------- assertions ----------------
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count_q <= (Q_AW+1)'(QDEPTH))
		else $error("result queue overfilled");

	a_line_store_ports: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("line store read and write hit the same column");

	a_frame_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.frame_last) |-> out_ch.run_last)
		else $error("frame end result not marked as last of its item");

	a_pop_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> out_v_q)
		else $error("queue pop lost before output register");

endmodule

`default_nettype wire

### rtl/bblur_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; contents are undefined until written.
`default_nettype none

module bblur_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### verif/tb_box_blur_3x3_edge_normalized_core.sv
// Testbench of the 3x3 border-normalized box blur: streams raster frames of height
// samples, predicts every mean and its coordinates, and checks each result item.
// Depends on bblur_pkg, bblur_in_if, bblur_out_if and box_blur_3x3_edge_normalized_core.
`timescale 1ns / 1ps

module tb_box_blur_3x3_edge_normalized_core;
	import bblur_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int MAX_GAP        = 20;

	typedef struct packed {
		logic [SAMPLE_W-1:0] mean;
		logic [COL_W-1:0]    col;
		logic [ROW_W-1:0]    row;
		logic                run_last;
		logic                frame_last;
	} pixel_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	bblur_in_if  in_ch();
	bblur_out_if out_ch();

	box_blur_3x3_edge_normalized_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Mirror of the block: two rows above, 3x3 window, position and frame size
	logic [SAMPLE_W-1:0] row_above2 [MAX_WIDTH];
	logic [SAMPLE_W-1:0] row_above1 [MAX_WIDTH];
	logic [SAMPLE_W-1:0] win [3][3];   // [column: 0 = c-2 .. 2 = c][row: 0 = r-2 .. 2 = r]
	int unsigned         col_pos;
	int unsigned         row_pos;
	logic [CFG_W-1:0]    width_reg;
	logic [CFG_W-1:0]    height_reg;

	pixel_t      expected_pixels [$];
	pixel_t      due_pixel;
	int unsigned err_cnt;
	int unsigned src_idle_pct;
	int unsigned snk_stall_pct;
	int unsigned quiet_cycles = 0;

	function automatic int unsigned eff_size(input logic [CFG_W-1:0] v, input int unsigned maxv);
		if (v < 2) begin
			return 2;
		end
		if (v > maxv) begin
			return maxv;
		end
		return v;
	endfunction

	function automatic pixel_t window_mean(input logic [2:0] colsel, input logic [2:0] rowsel,
		input int unsigned x, input int unsigned y, input logic corner);
		int unsigned sum;
		int unsigned n;
		int          i;
		int          j;
		pixel_t      p;
		sum = 0;
		n = 0;
		for (i = 0; i < 3; i++) begin
			for (j = 0; j < 3; j++) begin
				if (colsel[i] && rowsel[j]) begin
					sum += win[i][j];
					n++;
				end
			end
		end
		// round half up
		p.mean       = SAMPLE_W'((sum + n / 2) / n);
		p.col        = COL_W'(x);
		p.row        = ROW_W'(y);
		p.run_last   = 1'b0;
		p.frame_last = corner;
		return p;
	endfunction

	function automatic void predict_blur(input logic [SAMPLE_W-1:0] s);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		int unsigned k;
		int          i;
		logic [2:0]  lead;
		logic [2:0]  rows_up;
		pixel_t      res [4];
		w = eff_size(width_reg, MAX_WIDTH);
		h = eff_size(height_reg, MAX_HEIGHT);
		// a size that shrank under the current position cuts the row or the frame
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h) begin
			row_pos = 0;
		end
		c = col_pos;
		r = row_pos;
		for (i = 0; i < 3; i++) begin
			win[0][i] = win[1][i];
			win[1][i] = win[2][i];
		end
		win[2][0] = row_above2[c];
		win[2][1] = row_above1[c];
		win[2][2] = s;
		row_above2[c] = row_above1[c];
		row_above1[c] = s;
		lead    = (c >= 2) ? 3'b111 : 3'b110;
		rows_up = (r >= 2) ? 3'b111 : 3'b110;
		k = 0;
		if (r >= 1) begin
			if (c >= 1) begin
				res[k] = window_mean(lead, rows_up, c - 1, r - 1, 1'b0);
				k++;
			end
			if (c == w - 1) begin
				res[k] = window_mean(3'b110, rows_up, c, r - 1, 1'b0);
				k++;
			end
		end
		if (r == h - 1) begin
			if (c >= 1) begin
				res[k] = window_mean(lead, 3'b110, c - 1, r, 1'b0);
				k++;
			end
			if (c == w - 1) begin
				res[k] = window_mean(3'b110, 3'b110, c, r, 1'b1);
				k++;
			end
		end
		for (i = 0; i < k; i++) begin
			if (i == k - 1) begin
				res[i].run_last = 1'b1;
			end
			expected_pixels.push_back(res[i]);
		end
		col_pos = c + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= h) begin
				row_pos = 0;
			end
		end
	endfunction

	function automatic logic [SAMPLE_W-1:0] rand_height();
		case ($urandom_range(19))
			0:       return '0;
			1:       return SAMPLE_W'(32768);
			2:       return SAMPLE_W'($urandom_range(65535));
			default: return SAMPLE_W'($urandom_range(32768));
		endcase
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			err_cnt++;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FRAME_WIDTH) begin
			width_reg = val;
		end else begin
			height_reg = val;
		end
		@(posedge clk);
	endtask

	task automatic send_sample(input logic [SAMPLE_W-1:0] s);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < src_idle_pct && gap < MAX_GAP) begin
			gap++;
		end
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.sample_in <= s;
		do begin
			@(posedge clk);
		end while (!in_ch.ready);
		predict_blur(s);
	endtask

	// Hold the input until every pending result is out and the pipeline is quiet
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (expected_pixels.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_size_clamp_and_row_cut();
		// all-ones width acts as the maximum, height 1 acts as 2
		write_reg(REG_FRAME_WIDTH, '1);
		write_reg(REG_FRAME_HEIGHT, CFG_W'(1));
		send_sample('0);
		send_sample(SAMPLE_W'(32768));
		send_sample(SAMPLE_W'(65535));
		send_sample(SAMPLE_W'(1));
		wait_drained();
		// column 4 now lies past the width: the row ends and the last row starts
		write_reg(REG_FRAME_WIDTH, CFG_W'(3));
		send_sample(SAMPLE_W'(65535));
		send_sample(SAMPLE_W'(32768));
		send_sample('0);
		wait_drained();
	endtask

	task automatic test_height_cut();
		write_reg(REG_FRAME_WIDTH, CFG_W'(3));
		write_reg(REG_FRAME_HEIGHT, HEIGHT_MAX);
		repeat (3) send_sample(SAMPLE_W'(65535));
		send_sample(SAMPLE_W'(32768));
		send_sample(SAMPLE_W'(65535));
		send_sample(SAMPLE_W'(1));
		send_sample(SAMPLE_W'(32767));
		send_sample('0);
		send_sample(SAMPLE_W'(65535));
		wait_drained();
		// row 3 lies past the new height: a fresh frame starts at row 0
		write_reg(REG_FRAME_WIDTH, SIZE_MIN);
		write_reg(REG_FRAME_HEIGHT, SIZE_MIN);
		send_sample(SAMPLE_W'(32768));
		send_sample('0);
		send_sample(SAMPLE_W'(32767));
		send_sample(SAMPLE_W'(16'h5555));
		wait_drained();
	endtask

	task automatic test_random_frames(input int unsigned n_items, input int unsigned idle_pct,
		input int unsigned stall_pct);
		int unsigned sent;
		int unsigned w;
		int unsigned h;
		int unsigned i;
		src_idle_pct  = idle_pct;
		snk_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_items) begin
			// mostly small frames, now and then a size below the minimum
			write_reg(REG_FRAME_WIDTH, ($urandom_range(7) == 0) ?
				CFG_W'($urandom_range(1)) : CFG_W'($urandom_range(2, 9)));
			write_reg(REG_FRAME_HEIGHT, ($urandom_range(7) == 0) ?
				CFG_W'($urandom_range(1)) : CFG_W'($urandom_range(2, 7)));
			w = eff_size(width_reg, MAX_WIDTH);
			h = eff_size(height_reg, MAX_HEIGHT);
			for (i = 0; i < w * h; i++) begin
				if ($urandom_range(39) == 0) begin
					wait_drained();
				end
				send_sample(rand_height());
			end
			sent += w * h;
			wait_drained();
		end
	endtask

	// Result checker and receiver stalls
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: result with none pending: mean %0d column %0d row %0d",
					$time, out_ch.blurred_sample, out_ch.out_column, out_ch.out_row);
				err_cnt++;
			end else begin
				due_pixel = expected_pixels.pop_front();
				check_field("blurred_sample", due_pixel.mean, out_ch.blurred_sample);
				check_field("out_column", due_pixel.col, out_ch.out_column);
				check_field("out_row", due_pixel.row, out_ch.out_row);
				check_field("run_last", due_pixel.run_last, out_ch.run_last);
				check_field("frame_last", due_pixel.frame_last, out_ch.frame_last);
			end
		end
		out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("tb_box_blur_3x3_edge_normalized_core: errors");
			$finish;
		end
	end

	initial begin
		in_ch.valid     = 1'b0;
		in_ch.sample_in = '0;
		out_ch.ready    = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = REG_FRAME_WIDTH;
		cfg_data        = '0;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			row_above2[i] = '0;
			row_above1[i] = '0;
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				win[i][j] = '0;
			end
		end
		col_pos       = 0;
		row_pos       = 0;
		width_reg     = SIZE_RESET;
		height_reg    = SIZE_RESET;
		err_cnt       = 0;
		src_idle_pct  = 17;
		snk_stall_pct = 52;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_size_clamp_and_row_cut();
		test_height_cut();
		test_random_frames(50, 17, 52);
		test_random_frames(50, 52, 17);
		test_random_frames(50, 0, 0);

		if (err_cnt == 0) begin
			$display("tb_box_blur_3x3_edge_normalized_core: clean");
		end else begin
			$display("tb_box_blur_3x3_edge_normalized_core: errors");
		end
		$finish;
	end

endmodule
